// ===== sv/box_blur_3x3_rgb_top_assert.svh =====
// Assertion macros for the 3x3 box blur block.
// Expects clk and rst in the scope of the module that uses them.
`ifndef BOX_BLUR_3X3_RGB_TOP_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_TOP_ASSERT_SVH

// Check an expression on every clock edge outside reset.
`define BB3_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// Check that a condition leads to an effect in the next clock cycle.
`define BB3_CHECK_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

// ===== sv/bb3_pkg.sv =====
// Shared constants, types and helpers for the 3x3 box blur block.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_ROWS  = 1024;

  localparam int CHAN_W   = 8;
  localparam int CHANS    = 3;
  localparam int PIX_W    = CHANS * CHAN_W;
  localparam int CHAN_MAX = (1 << CHAN_W) - 1;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WCNT_W   = COL_W + 1;
  localparam int SIZE_W   = 11;
  localparam int ROW_W    = 11;
  localparam int PEND_W   = 21;
  localparam int SUM_W    = CHAN_W + 4;
  localparam int CNT_W    = 4;
  localparam int NUM_W    = SUM_W + 1;
  localparam int RECIP_SH = 18;
  localparam int RECIP_W  = RECIP_SH;
  localparam int PROD_W   = NUM_W + RECIP_W;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd1024;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic              emit;
    logic              fe;
    logic              top_ok;
    logic              bot_ok;
    logic              use_w1;
    logic              use_cur;
    logic [CNT_W-1:0]  cnt;
    logic [COL_W-1:0]  ci;
    pix_t              pix;
  } adv_t;

  // Channel 0 is red, in the top byte.
  function automatic logic [CHAN_W-1:0] chan_of(pix_t p, int ch);
    chan_of = p[PIX_W-1-ch*CHAN_W -: CHAN_W];
  endfunction

  // ceil(2^RECIP_SH / (2*n)), exact for every numerator 2*sum+n that can occur.
  function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] n);
    case (n)
      4'd1:    recip = 18'd131072;
      4'd2:    recip = 18'd65536;
      4'd3:    recip = 18'd43691;
      4'd4:    recip = 18'd32768;
      4'd6:    recip = 18'd21846;
      4'd9:    recip = 18'd14564;
      default: recip = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== sv/bb3_if.sv =====
// Stream interfaces for the 3x3 box blur block: pixel words in, blurred words out.
// Depends on bb3_pkg.
`default_nettype none

interface bb3_pix_if;
  import bb3_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [CHAN_W-1:0] pix_red;
  logic [CHAN_W-1:0] pix_green;
  logic [CHAN_W-1:0] pix_blue;
  modport source (output valid, action, pix_red, pix_green, pix_blue, input ready);
  modport sink   (input valid, action, pix_red, pix_green, pix_blue, output ready);
endinterface

interface bb3_res_if;
  import bb3_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              frame_end;
  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

`default_nettype wire

// ===== sv/box_blur_3x3_rgb_top.sv =====
// 3x3 box blur over RGB raster words with two line stores and rounded mean.
// Depends on bb3_pkg, bb3_if.sv and box_blur_3x3_rgb_top_assert.svh.
//
//   port      direction  handshake          word
//   pixels    in         valid/ready        action, pix_red, pix_green, pix_blue
//   results   out        valid/ready        out_red, out_green, out_blue, frame_end
//   apb       in         psel/penable       image_width @0x0, image_height @0x4
//
// One word a cycle while the output does not stall; the first drain word of a one-row frame
// also issues a second step, with a second line store access, and holds intake for it.
// A result passes through the s1, s2 and s3 registers to reach the output register.
// Line stores: one read and one write port each, read data registered; back-to-back
// accesses to one column (one-pixel rows) are forwarded.
// Synchronous reset clears position, counts and valid flags; the stores need no clearing.
// A result held at the output stalls the pipe only once the stage behind it is full.
`default_nettype none
`include "box_blur_3x3_rgb_top_assert.svh"

module box_blur_3x3_rgb_top (
  input  logic                        clk,
  input  logic                        rst,
  bb3_pix_if.sink                     pixels,
  bb3_res_if.source                   results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bb3_pkg::ADDR_W-1:0]  paddr,
  input  logic [bb3_pkg::DATA_W-1:0]  pwdata,
  output logic [bb3_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bb3_pkg::*;

  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic              cfg_wr;
  logic              reg_sel;
  logic [WCNT_W-1:0] eff_w;
  logic [ROW_W-1:0]  eff_h;

  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [PEND_W-1:0] outputs_pending;
  logic              extra;

  logic              en;
  logic              acc;
  logic              take_pix;
  logic              take_drain;
  logic              adv_go;
  logic              adv_drain;
  logic              last;
  adv_t              adv;
  logic [1:0]        ncols;
  logic [1:0]        nrows;
  logic [WCNT_W-1:0] col_inc;
  logic              wrap;
  logic [ROW_W-1:0]  row_m1;

  pix_t              mem_upper [MAX_WIDTH];
  pix_t              mem_middle [MAX_WIDTH];
  pix_t              rd_u;
  pix_t              rd_m;

  logic              s1_valid;
  adv_t              s1;
  logic              fwd_hit;
  pix_t              fwd_u;
  pix_t              fwd_m;
  pix_t              col [3];
  pix_t              win0 [3];
  pix_t              win1 [3];
  logic [2:0]        row_ok;
  logic [SUM_W-1:0]  sum_c [CHANS];

  logic              s2_valid;
  logic              s2_fe;
  logic [CNT_W-1:0]  s2_cnt;
  logic [SUM_W-1:0]  s2_sum [CHANS];
  logic [NUM_W-1:0]  num [CHANS];
  logic [RECIP_W-1:0] rcp;

  logic              s3_valid;
  logic              s3_fe;
  logic [PROD_W-1:0] s3_prod [CHANS];
  logic [NUM_W-1:0]  q [CHANS];
  logic [CHAN_W-1:0] qc [CHANS];

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = paddr[ADDR_W-1];
  assign prdata  = DATA_W'((reg_sel == REG_HEIGHT) ? image_height : image_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_WIDTH:  image_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: image_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      eff_w = WCNT_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_w = WCNT_W'(MAX_WIDTH);
    end else begin
      eff_w = WCNT_W'(image_width);
    end
    if (image_height == '0) begin
      eff_h = ROW_W'(1);
    end else if (int'(image_height) > MAX_ROWS) begin
      eff_h = ROW_W'(MAX_ROWS);
    end else begin
      eff_h = ROW_W'(image_height);
    end
  end

  // intake and raster position
  assign en            = !(s3_valid && results.valid && !results.ready);
  assign pixels.ready  = en && !extra;
  assign acc           = pixels.valid && pixels.ready;
  assign take_pix      = acc && (pixels.action == ACT_PIXEL) && (in_row < eff_h);
  assign take_drain    = acc && (pixels.action == ACT_DRAIN) && (in_row >= eff_h)
                         && (outputs_pending != '0);
  assign adv_go        = take_pix || take_drain || (extra && en);
  assign adv_drain     = take_drain || extra;
  assign row_m1        = in_row - ROW_W'(1);
  assign col_inc       = WCNT_W'(in_col) + WCNT_W'(1);
  assign wrap          = col_inc >= eff_w;

  always_comb begin
    if (in_col == '0) begin
      adv.emit    = in_row >= ROW_W'(2);
      adv.top_ok  = in_row >= ROW_W'(3);
      adv.bot_ok  = row_m1 < eff_h;
      adv.use_w1  = eff_w >= WCNT_W'(2);
      adv.use_cur = 1'b0;
    end else begin
      adv.emit    = in_row >= ROW_W'(1);
      adv.top_ok  = in_row >= ROW_W'(2);
      adv.bot_ok  = in_row < eff_h;
      adv.use_w1  = in_col >= COL_W'(2);
      adv.use_cur = 1'b1;
    end
    ncols   = 2'd1 + 2'(adv.use_w1) + 2'(adv.use_cur);
    nrows   = 2'd1 + 2'(adv.top_ok) + 2'(adv.bot_ok);
    adv.cnt = CNT_W'(ncols) * CNT_W'(nrows);
    adv.ci  = in_col;
    adv.pix = take_pix ? {pixels.pix_red, pixels.pix_green, pixels.pix_blue} : '0;
    last    = adv_drain && adv.emit && (outputs_pending == PEND_W'(1));
    adv.fe  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row          <= '0;
      in_col          <= '0;
      outputs_pending <= '0;
      extra           <= 1'b0;
    end else if (cfg_wr) begin
      in_row          <= '0;
      in_col          <= '0;
      outputs_pending <= '0;
      extra           <= 1'b0;
    end else if (adv_go) begin
      extra <= take_drain && !adv.emit;
      if (last) begin
        in_row          <= '0;
        in_col          <= '0;
        outputs_pending <= '0;
      end else begin
        in_col <= wrap ? '0 : col_inc[COL_W-1:0];
        in_row <= wrap ? in_row + ROW_W'(1) : in_row;
        if (adv_drain) begin
          outputs_pending <= outputs_pending - PEND_W'(adv.emit);
        end else begin
          outputs_pending <= outputs_pending + PEND_W'(!adv.emit);
        end
      end
    end
  end

  // line stores: read at intake, write back from stage s1
  always_ff @(posedge clk) begin
    if (adv_go) begin
      rd_u <= mem_upper[adv.ci];
      rd_m <= mem_middle[adv.ci];
    end
    if (s1_valid && en) begin
      mem_upper[s1.ci]  <= col[1];
      mem_middle[s1.ci] <= s1.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= adv_go;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1      <= adv;
      fwd_hit <= s1_valid && (s1.ci == adv.ci);
      fwd_u   <= col[1];
      fwd_m   <= s1.pix;
    end
  end

  // column assembly, window and channel sums
  always_comb begin
    col[0] = fwd_hit ? fwd_u : rd_u;
    col[1] = fwd_hit ? fwd_m : rd_m;
    col[2] = s1.pix;
    row_ok = {s1.bot_ok, 1'b1, s1.top_ok};
    for (int ch = 0; ch < CHANS; ch++) begin
      sum_c[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        if (row_ok[r]) begin
          if (s1.use_w1) begin
            sum_c[ch] = sum_c[ch] + SUM_W'(chan_of(win1[r], ch));
          end
          sum_c[ch] = sum_c[ch] + SUM_W'(chan_of(win0[r], ch));
          if (s1.use_cur) begin
            sum_c[ch] = sum_c[ch] + SUM_W'(chan_of(col[r], ch));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && en) begin
      for (int r = 0; r < 3; r++) begin
        win1[r] <= win0[r];
        win0[r] <= col[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1.emit;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cnt <= s1.cnt;
      s2_fe  <= s1.fe;
      for (int ch = 0; ch < CHANS; ch++) begin
        s2_sum[ch] <= sum_c[ch];
      end
    end
  end

  // rounded mean: (2*sum + n) / (2*n) by reciprocal
  always_comb begin
    rcp = recip(s2_cnt);
    for (int ch = 0; ch < CHANS; ch++) begin
      num[ch] = {s2_sum[ch], 1'b0} + NUM_W'(s2_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_fe <= s2_fe;
      for (int ch = 0; ch < CHANS; ch++) begin
        s3_prod[ch] <= PROD_W'(num[ch]) * PROD_W'(rcp);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < CHANS; ch++) begin
      q[ch]  = s3_prod[ch][PROD_W-1:RECIP_SH];
      qc[ch] = (q[ch] > NUM_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : q[ch][CHAN_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (s3_valid && en) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && en) begin
      results.out_red   <= qc[0];
      results.out_green <= qc[1];
      results.out_blue  <= qc[2];
      results.frame_end <= s3_fe;
    end
  end

  `BB3_CHECK(a_pending_bound, outputs_pending <= PEND_W'(eff_w) + PEND_W'(1), "pending count beyond one row plus one")
  `BB3_CHECK_NEXT(a_stall_hold, !en && !cfg_wr, $stable(in_row) && $stable(in_col), "position moved during stall")
  `BB3_CHECK_NEXT(a_second_step, extra && en, !extra, "second drain step not issued")
  `BB3_CHECK_NEXT(a_frame_done, adv_go && last, outputs_pending == '0 && in_row == '0 && in_col == '0, "frame end left state behind")

endmodule

`default_nettype wire
